/* rtl/mec_pkg.sv */
`default_nettype none

package mec_pkg;

	localparam int COUNT_W = 14;
	localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 14'd10000;

	typedef struct packed {
		logic signed [31:0] c_real;
		logic signed [31:0] c_imag;
	} point_t;

	typedef struct packed {
		logic [COUNT_W-1:0] iteration_count;
		logic               escaped;
	} result_t;

endpackage

`default_nettype wire

/* rtl/mandelbrot_escape_count.sv */
`default_nettype none

// Channel   Signals                            Handshake
// point     point_valid, point_stall, point    request taken when valid && !stall
// result    result_valid, result_stall, result request taken when valid && !stall
// cfg       cfg_valid, cfg_ready, cfg_data     write taken when valid && ready
//
// Each iteration steps through S_PROD, S_UPDATE, S_SQ_R, S_SQ_I and S_MAG.
// A last pass that leaves |zr| or |zi| >= 2 skips the squares and ends sooner.
// The single shared multiplier forms three products per iteration, and the
// update of z and the magnitude compare each have a state of their own.
// Reset is asynchronous and restores max_iterations to 10000.
// A finished result waits in the output register while a new request is taken.

module mandelbrot_escape_count #(
	parameter int FRAC_BITS = 27
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              point_valid,
	output logic                   point_stall,
	input  wire mec_pkg::point_t   point,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output mec_pkg::result_t       result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [mec_pkg::COUNT_W-1:0] cfg_data
);

	localparam int MW = FRAC_BITS + 2;
	localparam int PW = 2 * MW;
	localparam int ZW = ((FRAC_BITS + 5 > 32) ? FRAC_BITS + 5 : 32) + 1;
	localparam logic signed [ZW-1:0] TWO_Z = ZW'(1) << (FRAC_BITS + 1);
	localparam logic signed [ZW-1:0] NEG_TWO_Z = -TWO_Z;
	localparam logic signed [PW:0] FOUR_SQ = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROD,
		S_UPDATE,
		S_SQ_R,
		S_SQ_I,
		S_MAG,
		S_DONE
	} state_t;

	state_t state_q;

	logic [mec_pkg::COUNT_W-1:0] max_iter_q;
	logic [mec_pkg::COUNT_W-1:0] count_q;
	logic                        esc_q;
	logic signed [31:0]          c_real_q;
	logic signed [31:0]          c_imag_q;
	logic signed [ZW-1:0]        zr_q;
	logic signed [ZW-1:0]        zi_q;
	logic signed [PW-1:0]        rr_q;
	logic signed [PW-1:0]        ii_q;
	logic signed [PW-1:0]        ri_q;
	logic                        result_valid_q;
	mec_pkg::result_t            result_q;

	logic signed [MW-1:0] mul_a;
	logic signed [MW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW:0]   rdiff;
	logic signed [PW:0]   idbl;
	logic signed [PW:0]   rsh;
	logic signed [PW:0]   ish;
	logic signed [ZW-1:0] zr_next;
	logic signed [ZW-1:0] zi_next;
	logic signed [PW:0]   mag;
	logic                 big_z;
	logic                 out_free;

	always_comb begin
		unique case (state_q)
			S_PROD: begin
				mul_a = zr_q[MW-1:0];
				mul_b = zi_q[MW-1:0];
			end
			S_SQ_I: begin
				mul_a = zi_q[MW-1:0];
				mul_b = zi_q[MW-1:0];
			end
			default: begin
				mul_a = zr_q[MW-1:0];
				mul_b = zr_q[MW-1:0];
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign rdiff   = {rr_q[PW-1], rr_q} - {ii_q[PW-1], ii_q};
	assign idbl    = {ri_q, 1'b0};
	assign rsh     = rdiff >>> FRAC_BITS;
	assign ish     = idbl >>> FRAC_BITS;
	assign zr_next = ZW'(rsh) + ZW'(c_real_q);
	assign zi_next = ZW'(ish) + ZW'(c_imag_q);
	assign mag     = {rr_q[PW-1], rr_q} + {ii_q[PW-1], ii_q};
	assign big_z   = (zr_q >= TWO_Z) || (zr_q <= NEG_TWO_Z) ||
	                 (zi_q >= TWO_Z) || (zi_q <= NEG_TWO_Z);
	assign out_free = !result_valid_q || !result_stall;

	assign point_stall  = (state_q != S_IDLE);
	assign cfg_ready    = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			max_iter_q     <= mec_pkg::MAX_ITER_RESET;
			count_q        <= '0;
			esc_q          <= 1'b0;
			c_real_q       <= '0;
			c_imag_q       <= '0;
			zr_q           <= '0;
			zi_q           <= '0;
			rr_q           <= '0;
			ii_q           <= '0;
			ri_q           <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_iter_q <= cfg_data;
			end
			if (result_valid_q && !result_stall && state_q != S_DONE) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (point_valid) begin
						c_real_q <= point.c_real;
						c_imag_q <= point.c_imag;
						zr_q     <= '0;
						zi_q     <= '0;
						rr_q     <= '0;
						ii_q     <= '0;
						count_q  <= '0;
						esc_q    <= 1'b0;
						state_q  <= S_PROD;
					end
				end
				S_PROD: begin
					ri_q    <= prod;
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					zr_q    <= zr_next;
					zi_q    <= zi_next;
					count_q <= count_q + 1'b1;
					state_q <= S_SQ_R;
				end
				S_SQ_R: begin
					if (big_z) begin
						esc_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						rr_q    <= prod;
						state_q <= S_SQ_I;
					end
				end
				S_SQ_I: begin
					ii_q    <= prod;
					state_q <= S_MAG;
				end
				S_MAG: begin
					priority if (mag >= FOUR_SQ) begin
						esc_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (count_q >= max_iter_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_PROD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						result_q.iteration_count <= count_q;
						result_q.escaped         <= esc_q;
						result_valid_q           <= 1'b1;
						state_q                  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/mec_checker.sv */
`default_nettype none

module mec_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         point_valid,
	input wire logic                         point_stall,
	input wire logic                         result_valid,
	input wire logic                         result_stall,
	input wire mec_pkg::result_t             result,
	input wire logic                         cfg_ready
);

	// A stalled result holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Every result reports at least one iteration.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.iteration_count != '0)
		else $error("result with zero iterations");

	// Once a request is taken, the block is busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall |=> point_stall && !cfg_ready)
		else $error("block not busy after taking a request");

	// No result can appear in the cycle right after a request is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall |=> !$rose(result_valid))
		else $error("result appeared too early");

endmodule

bind mandelbrot_escape_count mec_checker u_mec_checker (.*);

`default_nettype wire
